FILE: hw/rtl/text_window_character_writer_macros.svh
// Assertion macros used by the RTL of the text window character writer.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef TEXT_WINDOW_CHARACTER_WRITER_MACROS_SVH
`define TEXT_WINDOW_CHARACTER_WRITER_MACROS_SVH

// Same-cycle implication, held off during reset.
`define TWCW_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define TWCW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/twcw_pkg.sv
// ----------------------------------------------------------------------------
// twcw_pkg
// Types, codes and constants shared by the text window character writer.
// ----------------------------------------------------------------------------
package twcw_pkg;

	localparam int unsigned TWCW_FIFO_DEPTH = 4;
	localparam int unsigned TWCW_PTR_W      = $clog2(TWCW_FIFO_DEPTH);
	localparam int unsigned TWCW_MAX_OPS    = 3;

	localparam logic [7:0] NEWLINE_CHAR = 8'd10;
	localparam logic [7:0] NUL_CHAR     = 8'd0;
	localparam logic [7:0] CURSOR_GLYPH = 8'h5f;
	localparam logic [7:0] FILL_GLYPH   = 8'd32;
	localparam logic [7:0] CURSOR_ATTR  = 8'd16;

	typedef enum logic [2:0] {
		CFG_SCREEN_COLUMNS = 3'd0,
		CFG_WINDOW_LEFT    = 3'd1,
		CFG_WINDOW_TOP     = 3'd2,
		CFG_WINDOW_WIDTH   = 3'd3,
		CFG_WINDOW_HEIGHT  = 3'd4,
		CFG_TEXT_COLOUR    = 3'd5,
		CFG_ATTRIBUTE_BITS = 3'd6,
		CFG_CONSOLE_MODE   = 3'd7
	} cfg_index_t;

	typedef enum logic {
		CMD_PUT  = 1'b0,
		CMD_GOTO = 1'b1
	} command_t;

	typedef enum logic {
		KIND_CELL   = 1'b0,
		KIND_SCROLL = 1'b1
	} kind_t;

	typedef struct packed {
		logic [7:0] screen_columns;
		logic [6:0] window_left;
		logic [5:0] window_top;
		logic [7:0] window_width;
		logic [6:0] window_height;
		logic [7:0] text_colour;
		logic [7:0] attribute_bits;
		logic [1:0] console_mode;
	} cfg_t;

	// One pending write: screen column and row, offset still to be formed.
	typedef struct packed {
		logic       kind;
		logic [7:0] col;
		logic [7:0] row;
		logic [7:0] glyph;
		logic [7:0] colour;
		logic       last;
	} op_t;

	// ASCII to screen code.
	function automatic logic [7:0] map_glyph(input logic [7:0] c);
		logic [7:0] g;
		if (c == 8'd95) begin
			g = 8'd100;
		end else if (c >= 8'd64 && c <= 8'd95) begin
			g = c - 8'd64;
		end else if (c >= 8'd96 && c < 8'd192) begin
			g = c - 8'd32;
		end else if (c >= 8'd192) begin
			g = c - 8'd128;
		end else begin
			g = c;
		end
		return g;
	endfunction

endpackage

FILE: hw/rtl/twcw_front.sv
// ----------------------------------------------------------------------------
// twcw_front
// Accepts requests, tracks the cursor and issues up to three writes a request.
// ----------------------------------------------------------------------------
module twcw_front (
	input  logic             clk,
	input  logic             arst_n,
	input  twcw_pkg::cfg_t   cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             command,
	input  logic [7:0]       char_code,
	input  logic [7:0]       pos_x,
	input  logic [7:0]       pos_y,
	output logic             push,
	output twcw_pkg::op_t    push_op,
	input  logic             full
);
	import twcw_pkg::*;

	logic [7:0] cursor_column_q, cursor_row_q;
	op_t        ops_q [TWCW_MAX_OPS];
	logic [1:0] n_q;

	op_t        ops_d [TWCW_MAX_OPS];
	logic [1:0] n_d;
	logic [7:0] col_d, row_d;
	logic [7:0] bottom, c1, r1, rr;
	op_t        scroll_op;
	logic       accept;

	assign push     = (n_q != 2'd0) && !full;
	assign push_op  = ops_q[0];
	assign in_ready = (n_q == 2'd0) || (n_q == 2'd1 && push);
	assign accept   = in_valid && in_ready;

	always_comb begin
		bottom = (cfg.window_height == 7'd0) ? 8'd0 : {1'b0, cfg.window_height - 7'd1};
		scroll_op.kind   = KIND_SCROLL;
		scroll_op.col    = {1'b0, cfg.window_left};
		scroll_op.row    = {2'b00, cfg.window_top};
		scroll_op.glyph  = FILL_GLYPH;
		scroll_op.colour = cfg.text_colour;
		scroll_op.last   = 1'b0;
		for (int i = 0; i < TWCW_MAX_OPS; i++) begin
			ops_d[i] = scroll_op;
		end
		n_d   = 2'd0;
		col_d = cursor_column_q;
		row_d = cursor_row_q;
		c1    = cursor_column_q + 8'd1;
		r1    = cursor_row_q + 8'd1;
		rr    = cursor_row_q;
		if (command == CMD_GOTO) begin
			col_d = pos_x;
			row_d = pos_y;
		end else if (char_code == NUL_CHAR) begin
			n_d = 2'd0;
		end else if (char_code == NEWLINE_CHAR) begin
			col_d = 8'd0;
			if (r1 > bottom) begin
				row_d = bottom;
				n_d   = 2'd1;
			end else begin
				row_d = r1;
			end
		end else if (cursor_column_q < cfg.window_width) begin
			ops_d[0].kind   = KIND_CELL;
			ops_d[0].col    = cursor_column_q + {1'b0, cfg.window_left};
			ops_d[0].row    = cursor_row_q + {2'b00, cfg.window_top};
			ops_d[0].glyph  = map_glyph(char_code);
			ops_d[0].colour = cfg.text_colour | cfg.attribute_bits;
			n_d = 2'd1;
			// auto-wrap: the scroll, if any, goes before the cursor write
			if (cfg.console_mode[0] && c1 >= cfg.window_width) begin
				c1 = 8'd0;
				if (r1 > bottom) begin
					rr  = bottom;
					n_d = 2'd2;
				end else begin
					rr = r1;
				end
			end
			if (cfg.console_mode[1]) begin
				ops_d[n_d].kind   = KIND_CELL;
				ops_d[n_d].col    = c1 + {1'b0, cfg.window_left};
				ops_d[n_d].row    = rr + {2'b00, cfg.window_top};
				ops_d[n_d].glyph  = CURSOR_GLYPH;
				ops_d[n_d].colour = cfg.text_colour | CURSOR_ATTR;
				n_d = n_d + 2'd1;
			end
			col_d = c1;
			row_d = rr;
		end
		for (int i = 0; i < TWCW_MAX_OPS; i++) begin
			ops_d[i].last = (2'(i) == n_d - 2'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q             <= 2'd0;
			cursor_column_q <= 8'd0;
			cursor_row_q    <= 8'd0;
		end else if (accept) begin
			n_q             <= n_d;
			cursor_column_q <= col_d;
			cursor_row_q    <= row_d;
		end else if (push) begin
			n_q <= n_q - 2'd1;
		end
	end

	// payload list: load on accept, else shift down on a push
	always_ff @(posedge clk) begin
		if (accept) begin
			ops_q <= ops_d;
		end else if (push) begin
			ops_q[0] <= ops_q[1];
			ops_q[1] <= ops_q[2];
		end
	end

endmodule

FILE: hw/rtl/twcw_fifo.sv
// ----------------------------------------------------------------------------
// twcw_fifo
// Short queue of pending writes between the front and the back.
// ----------------------------------------------------------------------------
`include "text_window_character_writer_macros.svh"

module twcw_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  twcw_pkg::op_t  push_op,
	output logic           full,
	input  logic           pop,
	output twcw_pkg::op_t  pop_op,
	output logic           empty
);
	import twcw_pkg::*;

	op_t                   mem_q [TWCW_FIFO_DEPTH];
	logic [TWCW_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [TWCW_PTR_W:0]   count_q;

	assign full   = (count_q == (TWCW_PTR_W+1)'(TWCW_FIFO_DEPTH));
	assign empty  = (count_q == '0);
	assign pop_op = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	`TWCW_ASSERT_IMPLIES(a_no_overflow, push, !full || pop, "write queue overflow")
	`TWCW_ASSERT_IMPLIES(a_no_underflow, pop, !empty, "write queue underflow")
	`TWCW_ASSERT_NEXT(a_count_tracks, push && !pop && !full, !empty, "queue count lost a push")

endmodule

FILE: hw/rtl/twcw_back.sv
// ----------------------------------------------------------------------------
// twcw_back
// Forms cell byte offsets and drives the result channel through a register.
// ----------------------------------------------------------------------------
module twcw_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     screen_columns,
	input  logic           empty,
	input  twcw_pkg::op_t  pop_op,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           kind,
	output logic [15:0]    cell_byte_offset,
	output logic [7:0]     glyph_code,
	output logic [7:0]     colour_byte,
	output logic           last
);
	import twcw_pkg::*;

	logic        valid_s1, out_valid_q;
	op_t         op_s1;
	logic [15:0] prod_s1;
	logic [15:0] sum;
	logic        out_free, adv;

	assign out_free = !out_valid_q || out_ready;
	assign adv      = valid_s1 && out_free;
	assign pop      = !empty && (!valid_s1 || adv);
	assign sum      = prod_s1 + {8'd0, op_s1.col};
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_s1   <= pop_op;
			prod_s1 <= pop_op.row * screen_columns;
		end
		if (adv) begin
			kind             <= op_s1.kind;
			cell_byte_offset <= {sum[14:0], 1'b0};
			glyph_code       <= op_s1.glyph;
			colour_byte      <= op_s1.colour;
			last             <= op_s1.last;
		end
	end

endmodule

FILE: hw/rtl/text_window_character_writer.sv
// ----------------------------------------------------------------------------
// text_window_character_writer
// Cursor-tracking writer that turns characters into text screen cell writes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one request per put-character or goto.
//   A goto, a zero byte or a character past the right edge yields no result.
//   A character yields its cell write, an optional scroll request and an
//   optional cursor write; a newline yields at most one scroll request.
//   The final result of a request carries last.
//   Output channel (out_valid/out_ready): one result per handshake.
//   Throughput: one result per cycle while out_ready is high; the front takes a
//   request as the previous one's last write issues, or at once if it had none.
//   The front issues one write a cycle while the 4-entry queue has room;
//   the back multiplies row by screen_columns in one stage, adds in the next.
//   Stalls: a held out_ready fills the output register, the multiply stage
//   and the queue in turn, then in_ready drops.
//   Reset: cursor at column 0, row 0, registers at their defaults, all
//   pipeline valids clear. Write configuration only while idle.
// ----------------------------------------------------------------------------
module text_window_character_writer (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  char_code,
	input  logic [7:0]  pos_x,
	input  logic [7:0]  pos_y,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [15:0] cell_byte_offset,
	output logic [7:0]  glyph_code,
	output logic [7:0]  colour_byte,
	output logic        last
);
	import twcw_pkg::*;

	cfg_t cfg_q;
	logic push, full, pop, empty;
	op_t  push_op, pop_op;

	// Configuration registers: decode the index, keep only each register's width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_columns <= 8'd40;
			cfg_q.window_left    <= 7'd0;
			cfg_q.window_top     <= 6'd0;
			cfg_q.window_width   <= 8'd40;
			cfg_q.window_height  <= 7'd25;
			cfg_q.text_colour    <= 8'd5;
			cfg_q.attribute_bits <= 8'd0;
			cfg_q.console_mode   <= 2'd0;
		end else if (cfg_write) begin
			case (cfg_index_t'(cfg_index))
				CFG_SCREEN_COLUMNS: cfg_q.screen_columns <= cfg_data;
				CFG_WINDOW_LEFT:    cfg_q.window_left    <= cfg_data[6:0];
				CFG_WINDOW_TOP:     cfg_q.window_top     <= cfg_data[5:0];
				CFG_WINDOW_WIDTH:   cfg_q.window_width   <= cfg_data;
				CFG_WINDOW_HEIGHT:  cfg_q.window_height  <= cfg_data[6:0];
				CFG_TEXT_COLOUR:    cfg_q.text_colour    <= cfg_data;
				CFG_ATTRIBUTE_BITS: cfg_q.attribute_bits <= cfg_data;
				CFG_CONSOLE_MODE:   cfg_q.console_mode   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Front: take requests, advance the cursor, issue one write a cycle unless full.
	twcw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.char_code (char_code),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.push      (push),
		.push_op   (push_op),
		.full      (full)
	);

	// Queue: decouple the cursor logic from the offset arithmetic.
	twcw_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (full),
		.pop     (pop),
		.pop_op  (pop_op),
		.empty   (empty)
	);

	// Back: form the byte offset and hold the result until taken.
	twcw_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.screen_columns   (cfg_q.screen_columns),
		.empty            (empty),
		.pop_op           (pop_op),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.kind             (kind),
		.cell_byte_offset (cell_byte_offset),
		.glyph_code       (glyph_code),
		.colour_byte      (colour_byte),
		.last             (last)
	);

endmodule

FILE: test/tb_text_window_character_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_window_character_writer
// Self-checking bench for the text window character writer.
// A short scripted run starts from the reset settings. Its simple rows carry
// results typed in by hand, and every other row is predicted. Randomised runs
// follow under a range of window settings, from the narrowest to the widest.
// A local model of the cursor predicts every cell write and scroll request.
// The output checker compares each result with the oldest outstanding one.
// ----------------------------------------------------------------------------
module tb_text_window_character_writer;

	import twcw_pkg::*;

	localparam int SETTLE_LIMIT = 4000;     // cycles allowed for results to drain
	localparam int TAIL_CYCLES  = 12;       // latency margin once nothing is due
	localparam int RUN_LIMIT_NS = 2000000;  // hard stop for a hung run

	// One result as it leaves the block.
	typedef struct packed {
		kind_t       kind;
		logic [15:0] offset;
		logic [7:0]  glyph;
		logic [7:0]  colour;
		logic        last;
	} cell_write_t;

	// One line of the scripted run: a register write or a request.
	// typed_count < 0 means the local model decides the results.
	typedef struct {
		bit          is_reg;
		cfg_index_t  reg_index;
		logic [7:0]  reg_value;
		command_t    cmd;
		logic [7:0]  ch;
		logic [7:0]  px;
		logic [7:0]  py;
		int          typed_count;
		cell_write_t typed_write;
	} script_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_write;
	logic [2:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        command;
	logic [7:0]  char_code;
	logic [7:0]  pos_x;
	logic [7:0]  pos_y;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        kind;
	logic [15:0] cell_byte_offset;
	logic [7:0]  glyph_code;
	logic [7:0]  colour_byte;
	logic        last;

	text_window_character_writer u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.command          (command),
		.char_code        (char_code),
		.pos_x            (pos_x),
		.pos_y            (pos_y),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.kind             (kind),
		.cell_byte_offset (cell_byte_offset),
		.glyph_code       (glyph_code),
		.colour_byte      (colour_byte),
		.last             (last)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------------
	// Local model of the console: register copy, cursor and pending results
	// ------------------------------------------------------------------------
	cfg_t        shadow;
	logic [7:0]  caret_col;
	logic [7:0]  caret_row;
	cell_write_t step_writes [3];
	cell_write_t awaited_writes [$];
	script_row_t script [$];

	int failures       = 0;
	int requests_sent  = 0;
	int writes_checked = 0;
	int settings_used  = 0;
	int burst_left     = 0;

	// ASCII to screen code, split on the top bits of the character.
	function automatic logic [7:0] screen_code(input logic [7:0] ch);
		logic [7:0] g;
		case (ch[7:6])
			2'b11: begin
				g = ch - 8'd128;
			end
			2'b10: begin
				g = ch - 8'd32;
			end
			2'b01: begin
				if (ch == 8'd95) begin
					g = 8'd100;     // underscore has a glyph of its own
				end else if (ch[5]) begin
					g = ch - 8'd32;
				end else begin
					g = ch - 8'd64;
				end
			end
			default: begin
				g = ch;
			end
		endcase
		return g;
	endfunction

	// Byte offset of a screen cell; column and row arrive already wrapped.
	function automatic logic [15:0] screen_offset(input logic [7:0] col, input logic [7:0] row);
		int unsigned lin;
		lin = 2 * (int'(col) + int'(row) * int'(shadow.screen_columns));
		return lin[15:0];
	endfunction

	function automatic int add_write(input int n, input kind_t k, input logic [15:0] off,
			input logic [7:0] glyph, input logic [7:0] colour);
		step_writes[n] = '{k, off, glyph, colour, 1'b0};
		return n + 1;
	endfunction

	// Drop to column 0 of the next row; past the bottom, hold the last row
	// and ask for the window to be scrolled up.
	function automatic int advance_row(input int n);
		logic [7:0] bottom;
		int         m;
		bottom = (shadow.window_height == 7'd0) ? 8'd0 : {1'b0, shadow.window_height} - 8'd1;
		m = n;
		caret_col = 8'd0;
		caret_row = caret_row + 8'd1;
		if (caret_row > bottom) begin
			caret_row = bottom;
			m = add_write(m, KIND_SCROLL,
				screen_offset({1'b0, shadow.window_left}, {2'b00, shadow.window_top}),
				FILL_GLYPH, shadow.text_colour);
		end
		return m;
	endfunction

	// Apply one request to the model; results land in step_writes.
	function automatic int step_console(input command_t c, input logic [7:0] ch,
			input logic [7:0] px, input logic [7:0] py);
		int n;
		n = 0;
		if (c == CMD_GOTO) begin
			caret_col = px;
			caret_row = py;
		end else if (ch == NEWLINE_CHAR) begin
			n = advance_row(n);
		end else if (ch != NUL_CHAR && caret_col < shadow.window_width) begin
			n = add_write(n, KIND_CELL,
				screen_offset(caret_col + {1'b0, shadow.window_left},
					caret_row + {2'b00, shadow.window_top}),
				screen_code(ch), shadow.text_colour | shadow.attribute_bits);
			caret_col = caret_col + 8'd1;
			if (shadow.console_mode[0] && caret_col >= shadow.window_width) begin
				n = advance_row(n);
			end
			if (shadow.console_mode[1]) begin
				n = add_write(n, KIND_CELL,
					screen_offset(caret_col + {1'b0, shadow.window_left},
						caret_row + {2'b00, shadow.window_top}),
					CURSOR_GLYPH, shadow.text_colour | CURSOR_ATTR);
			end
		end
		if (n > 0) begin
			step_writes[n - 1].last = 1'b1;
		end
		return n;
	endfunction

	// ------------------------------------------------------------------------
	// Driving: requests and register writes change at the falling edge
	// ------------------------------------------------------------------------

	// Write one register and keep the model's copy in step.
	task automatic write_register(input cfg_index_t idx, input logic [7:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_SCREEN_COLUMNS: shadow.screen_columns = value;
			CFG_WINDOW_LEFT:    shadow.window_left    = value[6:0];
			CFG_WINDOW_TOP:     shadow.window_top     = value[5:0];
			CFG_WINDOW_WIDTH:   shadow.window_width   = value;
			CFG_WINDOW_HEIGHT:  shadow.window_height  = value[6:0];
			CFG_TEXT_COLOUR:    shadow.text_colour    = value;
			CFG_ATTRIBUTE_BITS: shadow.attribute_bits = value;
			CFG_CONSOLE_MODE:   shadow.console_mode   = value[1:0];
			default: ;
		endcase
	endtask

	// Offer one request and hold it until taken. Between bursts, drop valid
	// for a random gap. On acceptance, queue what the model predicts, or the
	// hand-typed result where the script gives one.
	task automatic issue(input command_t c, input logic [7:0] ch, input logic [7:0] px,
			input logic [7:0] py, input int typed_count, input cell_write_t typed_write,
			output int produced);
		int gap;
		int n;
		if (burst_left == 0) begin
			gap        = $urandom_range(1, 6);
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 4) == 0) begin
				burst_left = 48;    // a long stretch with no sender gaps
			end
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		burst_left = burst_left - 1;
		@(negedge clk);
		in_valid  <= 1'b1;
		command   <= c;
		char_code <= ch;
		pos_x     <= px;
		pos_y     <= py;
		do @(posedge clk); while (!in_ready);
		requests_sent = requests_sent + 1;
		n = step_console(c, ch, px, py);
		if (typed_count >= 0) begin
			n = typed_count;
			step_writes[0] = typed_write;
		end
		for (int i = 0; i < n; i++) begin
			awaited_writes.push_back(step_writes[i]);
		end
		produced = n;
	endtask

	// Drop valid, let every outstanding result come back, then allow the
	// pipeline latency so that result-less requests have finished too.
	task automatic settle();
		int waited;
		waited = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_writes.size() != 0 && waited < SETTLE_LIMIT) begin
			@(posedge clk);
			waited = waited + 1;
		end
		if (awaited_writes.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, awaited_writes.size());
			failures = failures + 1;
			awaited_writes.delete();
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	// ------------------------------------------------------------------------
	// Scripted run
	// ------------------------------------------------------------------------
	function automatic cell_write_t one_write(input kind_t k, input logic [15:0] off,
			input logic [7:0] glyph, input logic [7:0] colour);
		return '{k, off, glyph, colour, 1'b1};
	endfunction

	task automatic request_row(input command_t c, input logic [7:0] ch, input logic [7:0] px,
			input logic [7:0] py, input int typed_count, input cell_write_t typed_write);
		script_row_t r;
		r.is_reg      = 1'b0;
		r.reg_index   = CFG_SCREEN_COLUMNS;
		r.reg_value   = 8'd0;
		r.cmd         = c;
		r.ch          = ch;
		r.px          = px;
		r.py          = py;
		r.typed_count = typed_count;
		r.typed_write = typed_write;
		script.push_back(r);
	endtask

	task automatic register_row(input cfg_index_t idx, input logic [7:0] value);
		script_row_t r;
		r.is_reg      = 1'b1;
		r.reg_index   = idx;
		r.reg_value   = value;
		r.cmd         = CMD_PUT;
		r.ch          = 8'd0;
		r.px          = 8'd0;
		r.py          = 8'd0;
		r.typed_count = -1;
		r.typed_write = '0;
		script.push_back(r);
	endtask

	task automatic build_script();
		// Reset settings: 40 columns, 40x25 window at the origin, colour 5,
		// no attributes, no wrap, no cursor.
		request_row(CMD_PUT, 8'd65, 8'd0, 8'd0, 1, one_write(KIND_CELL, 16'd0, 8'd1, 8'd5));
		request_row(CMD_PUT, NUL_CHAR, 8'hff, 8'hff, 0, '0);
		request_row(CMD_GOTO, 8'd0, 8'd39, 8'd0, 0, '0);
		request_row(CMD_PUT, 8'd95, 8'd0, 8'd0, 1, one_write(KIND_CELL, 16'd78, 8'd100, 8'd5));
		// cursor now sits past the right edge: the character is dropped
		request_row(CMD_PUT, 8'd97, 8'd0, 8'd0, 0, '0);
		request_row(CMD_PUT, NEWLINE_CHAR, 8'd0, 8'd0, 0, '0);
		request_row(CMD_GOTO, 8'd0, 8'd0, 8'd24, 0, '0);
		// newline on the bottom row asks for a scroll
		request_row(CMD_PUT, NEWLINE_CHAR, 8'd0, 8'd0, 1,
			one_write(KIND_SCROLL, 16'd0, FILL_GLYPH, 8'd5));
		request_row(CMD_PUT, 8'd255, 8'd0, 8'd0, 1, one_write(KIND_CELL, 16'd1920, 8'd127, 8'd5));
		request_row(CMD_PUT, 8'd192, 8'd0, 8'd0, -1, '0);
		request_row(CMD_PUT, 8'd191, 8'd0, 8'd0, -1, '0);
		request_row(CMD_PUT, 8'd64, 8'd0, 8'd0, -1, '0);
		request_row(CMD_PUT, 8'd96, 8'd0, 8'd0, -1, '0);
		request_row(CMD_PUT, 8'd63, 8'd0, 8'd0, -1, '0);
		// goto far outside the window, then a newline wraps the row to 0
		request_row(CMD_GOTO, 8'd0, 8'hff, 8'hff, -1, '0);
		request_row(CMD_PUT, NEWLINE_CHAR, 8'd0, 8'd0, -1, '0);
		request_row(CMD_PUT, 8'd1, 8'd0, 8'd0, -1, '0);
		// Widest screen, window at the far corner, two columns, zero height
		// (treated as one row), wrap and cursor on: a character can cause a
		// cell write, a scroll request and a cursor write.
		register_row(CFG_SCREEN_COLUMNS, 8'd255);
		register_row(CFG_WINDOW_LEFT, 8'd127);
		register_row(CFG_WINDOW_TOP, 8'd63);
		register_row(CFG_WINDOW_WIDTH, 8'd2);
		register_row(CFG_WINDOW_HEIGHT, 8'd0);
		register_row(CFG_TEXT_COLOUR, 8'd255);
		register_row(CFG_ATTRIBUTE_BITS, 8'hf0);
		register_row(CFG_CONSOLE_MODE, 8'd3);
		request_row(CMD_GOTO, 8'd0, 8'd0, 8'd0, -1, '0);
		request_row(CMD_PUT, 8'd65, 8'd0, 8'd0, -1, '0);
		request_row(CMD_PUT, 8'd66, 8'd0, 8'd0, -1, '0);
		request_row(CMD_PUT, NEWLINE_CHAR, 8'd0, 8'd0, -1, '0);
		// zero width: every character is dropped
		register_row(CFG_WINDOW_WIDTH, 8'd0);
		request_row(CMD_PUT, 8'd67, 8'd0, 8'd0, 0, '0);
	endtask

	// ------------------------------------------------------------------------
	// Randomised runs
	// ------------------------------------------------------------------------
	function automatic cfg_t setting(input logic [7:0] cols, input logic [6:0] left,
			input logic [5:0] top, input logic [7:0] width, input logic [6:0] height,
			input logic [7:0] colour, input logic [7:0] attr, input logic [1:0] mode);
		cfg_t s;
		s.screen_columns = cols;
		s.window_left    = left;
		s.window_top     = top;
		s.window_width   = width;
		s.window_height  = height;
		s.text_colour    = colour;
		s.attribute_bits = attr;
		s.console_mode   = mode;
		return s;
	endfunction

	// Mostly in-window gotos, characters and newlines; a few wild gotos and
	// zero bytes as noise. Every request counts towards the quota.
	task automatic run_phase(input cfg_t s, input int quota);
		int counted;
		int pick;
		int n;
		logic [7:0] ch;
		logic [7:0] px;
		logic [7:0] py;
		settle();
		write_register(CFG_SCREEN_COLUMNS, s.screen_columns);
		write_register(CFG_WINDOW_LEFT, {1'b0, s.window_left});
		write_register(CFG_WINDOW_TOP, {2'b00, s.window_top});
		write_register(CFG_WINDOW_WIDTH, s.window_width);
		write_register(CFG_WINDOW_HEIGHT, {1'b0, s.window_height});
		write_register(CFG_TEXT_COLOUR, s.text_colour);
		write_register(CFG_ATTRIBUTE_BITS, s.attribute_bits);
		write_register(CFG_CONSOLE_MODE, {6'd0, s.console_mode});
		settings_used = settings_used + 1;
		counted = 0;
		while (counted < quota) begin
			pick  = $urandom_range(0, 99);
			ch    = 8'($urandom_range(1, 255));
			px    = 8'($urandom_range(0, 255));
			py    = 8'($urandom_range(0, 255));
			if (pick < 8) begin
				px = 8'($urandom_range(0, int'(shadow.window_width)));
				py = 8'($urandom_range(0, int'(shadow.window_height)));
				issue(CMD_GOTO, ch, px, py, -1, '0, n);
			end else if (pick < 11) begin
				issue(CMD_GOTO, ch, px, py, -1, '0, n);
			end else begin
				if (pick < 14) begin
					ch = NUL_CHAR;
				end else if (pick < 28) begin
					ch = NEWLINE_CHAR;
				end
				issue(CMD_PUT, ch, px, py, -1, '0, n);
			end
			counted = counted + 1;
		end
	endtask

	// ------------------------------------------------------------------------
	// Receiver: out_ready follows a repeating stall pattern, redrawn at random, that sets it high or low in its cycles
	// ------------------------------------------------------------------------
	logic [15:0] stall_pattern = 16'hffff;
	logic [7:0]  stall_tick    = 8'd0;

	always @(negedge clk) begin
		stall_tick <= stall_tick + 8'd1;
		if (stall_tick[5:0] == 6'd63) begin
			case ($urandom_range(0, 3))
				0: stall_pattern <= 16'hffff;                           // no stalls
				1: stall_pattern <= 16'($urandom) | 16'h0001;           // random
				2: stall_pattern <= 16'($urandom & $urandom) | 16'h0001; // heavy
				default: stall_pattern <= 16'hf00f;                     // long stall
			endcase
		end
		out_ready <= stall_pattern[stall_tick[3:0]];
	end

	// ------------------------------------------------------------------------
	// Checker: every accepted result against the oldest outstanding one
	// ------------------------------------------------------------------------
	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
			failures = failures + 1;
		end
	endfunction

	always @(posedge clk) begin : check_results
		cell_write_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_writes.size() == 0) begin
				$display("%0t: unexpected result kind %0d offset %0d glyph %0d colour %0d last %0d",
					$time, kind, cell_byte_offset, glyph_code, colour_byte, last);
				failures = failures + 1;
			end else begin
				want = awaited_writes.pop_front();
				check_field("kind", 16'(want.kind), 16'(kind));
				check_field("cell_byte_offset", want.offset, cell_byte_offset);
				check_field("glyph_code", 16'(want.glyph), 16'(glyph_code));
				check_field("colour_byte", 16'(want.colour), 16'(colour_byte));
				check_field("last", 16'(want.last), 16'(last));
				writes_checked = writes_checked + 1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : main
		int n;
		arst_n    = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_SCREEN_COLUMNS;
		cfg_data  = 8'd0;
		in_valid  = 1'b0;
		command   = CMD_PUT;
		char_code = 8'd0;
		pos_x     = 8'd0;
		pos_y     = 8'd0;
		shadow    = setting(8'd40, 7'd0, 6'd0, 8'd40, 7'd25, 8'd5, 8'd0, 2'd0);
		caret_col = 8'd0;
		caret_row = 8'd0;
		build_script();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		settings_used = 1;

		// Walk the script; settle before each register write.
		foreach (script[i]) begin
			if (script[i].is_reg) begin
				settle();
				write_register(script[i].reg_index, script[i].reg_value);
			end else begin
				issue(script[i].cmd, script[i].ch, script[i].px, script[i].py,
					script[i].typed_count, script[i].typed_write, n);
			end
		end

		// Small window with wrap and cursor: frequent scrolls and triple results.
		run_phase(setting(8'd40, 7'd3, 6'd2, 8'd4, 7'd3, 8'd7, 8'h30, 2'd3), 24);
		// Largest values everywhere; offsets wrap past 16 bits.
		run_phase(setting(8'd255, 7'd127, 6'd63, 8'd255, 7'd127, 8'd255, 8'hff, 2'd3), 22);
		// Smallest legal window: one cell, wrap only.
		run_phase(setting(8'd1, 7'd0, 6'd0, 8'd1, 7'd1, 8'd0, 8'd0, 2'd1), 22);
		// Zero columns, width and height: drops, and scrolls on newlines.
		run_phase(setting(8'd0, 7'd0, 6'd0, 8'd0, 7'd0, 8'h5a, 8'ha5, 2'd2), 18);
		// Wide screen, window off to the side, cursor only.
		run_phase(setting(8'd128, 7'd100, 6'd40, 8'd20, 7'd5, 8'h0f, 8'h40, 2'd2), 22);
		// Reset values again, no wrap, no cursor.
		run_phase(setting(8'd40, 7'd0, 6'd0, 8'd40, 7'd25, 8'd5, 8'd0, 2'd0), 22);
		// Two draws of random settings with narrow windows.
		repeat (2) begin
			run_phase(setting(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
				6'($urandom_range(0, 63)), 8'($urandom_range(0, 12)),
				7'($urandom_range(0, 6)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 2'($urandom_range(0, 3))), 16);
		end

		settle();
		$display("Covered %0d requests and checked %0d results over %0d register settings,",
			requests_sent, writes_checked, settings_used);
		$display("including wrap, cursor, scroll, right-edge drops and zero-size windows.");
		if (failures == 0) begin
			$display("text_window_character_writer test passed");
		end else begin
			$display("text_window_character_writer test failed");
		end
		$finish;
	end

	// Hard stop in case the block hangs a handshake.
	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("%0t: run did not finish in time", $time);
		$display("text_window_character_writer test failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/twcw_pkg.sv
hw/rtl/twcw_front.sv
hw/rtl/twcw_fifo.sv
hw/rtl/twcw_back.sv
hw/rtl/text_window_character_writer.sv
test/tb_text_window_character_writer.sv
